### rtl/core/pci_pkg.sv
`default_nettype none
package pci_pkg;

    localparam int VW = 32;
    localparam int NW = 16;
    localparam int DIFF_W = 33;
    localparam int PROD_W = 49;
    localparam int SUM_W = 51;
    localparam int C16_W = 36;
    localparam int FAC_W = 17;
    localparam int DV_W = 38;
    localparam int M_W = 40;
    localparam int MHI_W = M_W - 32;
    localparam int R_W = 33;
    localparam int D_W = 41;
    localparam int ACC_W = 42;

    localparam int DIV_STAGES = 33;
    localparam int SHARE_STAGES = DIV_STAGES + 1;
    localparam int FRONT_STAGES = 6;
    localparam int ALIGN_STAGES = SHARE_STAGES - FRONT_STAGES;
    localparam int APPLY_STAGES = 3;
    localparam int VALID_STAGES = SHARE_STAGES + APPLY_STAGES;

    localparam logic [FAC_W-1:0] FAC_ONE = 17'd32768;
    localparam logic [15:0] RESTITUTION_RESET = 16'd32768;
    localparam logic REG_RESTITUTION = 1'b0;

    typedef logic [2:0][VW-1:0] vec_t;
    typedef logic [2:0][NW-1:0] nvec_t;

    typedef struct packed {
        vec_t va;
        vec_t vb;
        logic second;
        nvec_t n;
        logic [31:0] ima;
        logic [R_W-1:0] total;
    } item_t;

    typedef struct packed {
        vec_t va;
        vec_t vb;
        logic [2:0] neg;
    } carry_t;

    typedef struct packed {
        carry_t c;
        logic [2:0][M_W-1:0] m;
        logic pass;
    } front_t;

    typedef struct packed {
        logic [R_W-1:0] ra;
        logic [R_W-1:0] rb;
    } share_t;

    typedef struct packed {
        vec_t a;
        vec_t b;
        logic resolved;
    } result_t;

endpackage
`default_nettype wire

### rtl/core/pci_div.sv
`default_nettype none
module pci_div (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic [31:0]               ima,
    input  wire logic [pci_pkg::R_W-1:0]   total,
    output pci_pkg::share_t                share
);

    localparam int RW = pci_pkg::R_W;
    localparam int NS = pci_pkg::DIV_STAGES;

    logic [RW-1:0] rem_reg [NS];
    logic [RW-1:0] q_reg [NS];
    logic [RW-1:0] t_reg [NS];
    pci_pkg::share_t share_reg;
    pci_pkg::share_t share_next;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [RW:0] cand;
        logic [RW-1:0] tprev;
        logic [RW-1:0] qprev;
        logic qb;
        if (k == 0)
        begin : g_first
            assign cand = {2'b00, ima};
            assign tprev = total;
            assign qprev = '0;
        end
        else
        begin : g_next
            assign cand = {rem_reg[k-1], 1'b0};
            assign tprev = t_reg[k-1];
            assign qprev = q_reg[k-1];
        end
        assign qb = cand >= {1'b0, tprev};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= qb ? RW'(cand - {1'b0, tprev}) : cand[RW-1:0];
                q_reg[k] <= {qprev[RW-2:0], qb};
                t_reg[k] <= tprev;
            end
        end
    end

    // The two shares add up to one, less one unit when the division leaves a remainder.
    always_comb
    begin
        share_next.ra = q_reg[NS-1];
        share_next.rb = RW'({1'b1, 32'b0}) - q_reg[NS-1]
                      - RW'(rem_reg[NS-1] != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            share_reg <= share_next;
        end
    end

    assign share = share_reg;

endmodule
`default_nettype wire

### rtl/core/pci_front.sv
`default_nettype none
module pci_front (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [15:0]     restitution,
    input  pci_pkg::item_t       item,
    output pci_pkg::front_t      front
);

    localparam int VW = pci_pkg::VW;
    localparam int NW = pci_pkg::NW;
    localparam int DIFF_W = pci_pkg::DIFF_W;
    localparam int PROD_W = pci_pkg::PROD_W;
    localparam int SUM_W = pci_pkg::SUM_W;
    localparam int C16_W = pci_pkg::C16_W;
    localparam int FAC_W = pci_pkg::FAC_W;
    localparam int DV_W = pci_pkg::DV_W;
    localparam int M_W = pci_pkg::M_W;
    localparam int NST = pci_pkg::FRONT_STAGES;

    pci_pkg::carry_t carry_reg [NST];
    logic [2:0][NW-1:0] mag_reg [NST-1];
    logic tz_reg [2];
    logic pass_reg [NST-2];

    logic [DIFF_W-1:0] diff1_reg [3];
    logic [DIFF_W-1:0] diff1_next [3];
    logic [NW-1:0] n1_reg [3];
    logic [NW-1:0] mag1_next [3];
    logic signed [PROD_W-1:0] prod2_reg [3];
    logic signed [PROD_W-1:0] prod2_next [3];
    logic signed [SUM_W-1:0] s3_reg;
    logic signed [SUM_W-1:0] s3_next;
    logic [SUM_W-1:0] negs4;
    logic [C16_W-1:0] c16_4_reg;
    logic [FAC_W-1:0] fac;
    logic [C16_W+FAC_W-1:0] dvp5;
    logic [DV_W-1:0] dv5_reg;
    logic [DV_W+NW-1:0] mp6 [3];
    logic [2:0][M_W-1:0] m6_reg;
    pci_pkg::carry_t carry0;

    function automatic logic [FAC_W-1:0] FAC_ONE_ADD(input logic [15:0] e);
        FAC_ONE_ADD = pci_pkg::FAC_ONE + {1'b0, e};
    endfunction

    always_comb
    begin
        carry0.va = item.va;
        carry0.vb = item.vb;
        for (int i = 0; i < 3; i++)
        begin
            carry0.neg[i] = item.n[i][NW-1];
            diff1_next[i] = {item.va[i][VW-1], item.va[i]}
                          - (item.second ? {item.vb[i][VW-1], item.vb[i]} : '0);
            mag1_next[i] = item.n[i][NW-1] ? NW'(-item.n[i]) : item.n[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod2_next[i] = $signed(diff1_reg[i]) * $signed(n1_reg[i]);
        end
        s3_next = prod2_reg[0] + prod2_reg[1] + prod2_reg[2];
        negs4 = SUM_W'(-s3_reg);
        fac = FAC_ONE_ADD(restitution);
        dvp5 = c16_4_reg * fac;
        for (int i = 0; i < 3; i++)
        begin
            mp6[i] = dv5_reg * mag_reg[NST-2][i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            carry_reg[0] <= carry0;
            for (int k = 1; k < NST; k++)
            begin
                carry_reg[k] <= carry_reg[k-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[0][i] <= mag1_next[i];
                diff1_reg[i] <= diff1_next[i];
                n1_reg[i] <= item.n[i];
                prod2_reg[i] <= prod2_next[i];
                m6_reg[i] <= mp6[i][DV_W+NW-1:14];
            end
            for (int k = 1; k < NST - 1; k++)
            begin
                mag_reg[k] <= mag_reg[k-1];
            end
            tz_reg[0] <= item.total == '0;
            tz_reg[1] <= tz_reg[0];
            s3_reg <= s3_next;
            pass_reg[0] <= tz_reg[1] || (!s3_next[SUM_W-1] && (s3_next != '0));
            for (int k = 1; k < NST - 2; k++)
            begin
                pass_reg[k] <= pass_reg[k-1];
            end
            c16_4_reg <= negs4[C16_W+13:14];
            dv5_reg <= dvp5[C16_W+FAC_W-1:15];
        end
    end

    always_comb
    begin
        front.c = carry_reg[NST-1];
        front.m = m6_reg;
        front.pass = pass_reg[NST-3];
    end

endmodule
`default_nettype wire

### rtl/core/pci_apply.sv
`default_nettype none
module pci_apply (
    input  wire logic          clk,
    input  wire logic          en,
    input  pci_pkg::front_t    front,
    input  pci_pkg::share_t    share,
    output pci_pkg::result_t   result
);

    localparam int VW = pci_pkg::VW;
    localparam int R_W = pci_pkg::R_W;
    localparam int MHI_W = pci_pkg::MHI_W;
    localparam int M_W = pci_pkg::M_W;
    localparam int D_W = pci_pkg::D_W;
    localparam int ACC_W = pci_pkg::ACC_W;
    localparam int LO_W = 32 + R_W;
    localparam int HI_W = MHI_W + R_W;

    pci_pkg::carry_t carry1_reg;
    pci_pkg::carry_t carry2_reg;
    logic pass1_reg;
    logic pass2_reg;
    logic [LO_W-1:0] alo_reg [3];
    logic [LO_W-1:0] blo_reg [3];
    logic [HI_W-1:0] ahi_reg [3];
    logic [HI_W-1:0] bhi_reg [3];
    logic [D_W-1:0] da_reg [3];
    logic [D_W-1:0] db_reg [3];
    pci_pkg::result_t result_reg;
    pci_pkg::result_t result_next;

    function automatic logic [VW-1:0] sat(input logic [ACC_W-1:0] acc);
        logic top_same;
        top_same = (acc[ACC_W-1:VW-1] == '0) || (acc[ACC_W-1:VW-1] == '1);
        if (top_same)
        begin
            sat = acc[VW-1:0];
        end
        else if (acc[ACC_W-1])
        begin
            sat = {1'b1, {(VW-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(VW-1){1'b1}}};
        end
    endfunction

    always_comb
    begin
        logic [ACC_W-1:0] va;
        logic [ACC_W-1:0] vb;
        logic [ACC_W-1:0] sa;
        logic [ACC_W-1:0] sb;
        result_next.resolved = !pass2_reg;
        for (int i = 0; i < 3; i++)
        begin
            va = {{(ACC_W-VW){carry2_reg.va[i][VW-1]}}, carry2_reg.va[i]};
            vb = {{(ACC_W-VW){carry2_reg.vb[i][VW-1]}}, carry2_reg.vb[i]};
            sa = {{(ACC_W-D_W){1'b0}}, da_reg[i]};
            sb = {{(ACC_W-D_W){1'b0}}, db_reg[i]};
            if (pass2_reg)
            begin
                result_next.a[i] = carry2_reg.va[i];
                result_next.b[i] = carry2_reg.vb[i];
            end
            else if (carry2_reg.neg[i])
            begin
                result_next.a[i] = sat(va - sa);
                result_next.b[i] = sat(vb + sb);
            end
            else
            begin
                result_next.a[i] = sat(va + sa);
                result_next.b[i] = sat(vb - sb);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            carry1_reg <= front.c;
            carry2_reg <= carry1_reg;
            pass1_reg <= front.pass;
            pass2_reg <= pass1_reg;
            for (int i = 0; i < 3; i++)
            begin
                alo_reg[i] <= front.m[i][31:0] * share.ra;
                blo_reg[i] <= front.m[i][31:0] * share.rb;
                ahi_reg[i] <= front.m[i][M_W-1:32] * share.ra;
                bhi_reg[i] <= front.m[i][M_W-1:32] * share.rb;
                da_reg[i] <= D_W'({ahi_reg[i], 32'b0} >> 32)
                           + D_W'(alo_reg[i][LO_W-1:32]);
                db_reg[i] <= D_W'({bhi_reg[i], 32'b0} >> 32)
                           + D_W'(blo_reg[i][LO_W-1:32]);
            end
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

### rtl/core/pci_skid.sv
`default_nettype none
module pci_skid (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  pci_pkg::result_t   in_word,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output pci_pkg::result_t   out_word
);

    logic out_valid_reg;
    logic skid_valid_reg;
    pci_pkg::result_t out_reg;
    pci_pkg::result_t skid_reg;
    logic out_free;
    logic take;

    assign in_ready = !skid_valid_reg;
    assign take = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= take;
            end
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : in_word;
        end
        else if (take)
        begin
            skid_reg <= in_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word = out_reg;

endmodule
`default_nettype wire

### rtl/core/particle_contact_impulse_core.sv
// Throughput: one contact per cycle while the output skid register can take a word;
// the share divider is a 33-stage pipeline, one bit a stage.
// A full output skid register stalls every stage at once, so no word is lost or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits and sets restitution to 1.0.
`default_nettype none
module particle_contact_impulse_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z, normal_x, normal_y, normal_z,
    // inv_mass_a, inv_mass_b
    input  wire logic [303:0]  s_tdata,
    // has_second
    input  wire logic [0:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z
    output logic [191:0]       m_tdata,
    // resolved
    output logic [0:0]         m_tuser,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int VLD = pci_pkg::VALID_STAGES;
    localparam int ALN = pci_pkg::ALIGN_STAGES;

    logic en;
    logic [15:0] restitution_reg;
    logic in_valid_reg;
    logic vld_reg [VLD];
    pci_pkg::item_t item_reg;
    pci_pkg::item_t item_next;
    pci_pkg::front_t front;
    pci_pkg::front_t dly_reg [ALN];
    pci_pkg::share_t share;
    pci_pkg::result_t result;
    pci_pkg::result_t out_word;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pci_pkg::REG_RESTITUTION) ? {16'b0, restitution_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restitution_reg <= pci_pkg::RESTITUTION_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == pci_pkg::REG_RESTITUTION))
        begin
            restitution_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            item_next.va[i] = s_tdata[32*i +: 32];
            item_next.vb[i] = s_tdata[96 + 32*i +: 32];
            item_next.n[i] = s_tdata[192 + 16*i +: 16];
        end
        item_next.second = s_tuser[0];
        item_next.ima = s_tdata[271:240];
        item_next.total = {1'b0, s_tdata[271:240]}
                        + (s_tuser[0] ? {1'b0, s_tdata[303:272]} : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            for (int k = 0; k < VLD; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            in_valid_reg <= s_tvalid;
            vld_reg[0] <= in_valid_reg;
            for (int k = 1; k < VLD; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
            dly_reg[0] <= front;
            for (int k = 1; k < ALN; k++)
            begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    pci_front u_front (
        .clk         (clk),
        .en          (en),
        .restitution (restitution_reg),
        .item        (item_reg),
        .front       (front)
    );

    pci_div u_div (
        .clk   (clk),
        .en    (en),
        .ima   (item_reg.ima),
        .total (item_reg.total),
        .share (share)
    );

    pci_apply u_apply (
        .clk    (clk),
        .en     (en),
        .front  (dly_reg[ALN-1]),
        .share  (share),
        .result (result)
    );

    pci_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[VLD-1]),
        .in_word   (result),
        .in_ready  (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign s_tready = en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m_tdata[32*i +: 32] = out_word.a[i];
            m_tdata[96 + 32*i +: 32] = out_word.b[i];
        end
        m_tuser[0] = out_word.resolved;
    end

endmodule
`default_nettype wire

### rtl/core/pci_checker.sv
`default_nettype none
module pci_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tready,
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [191:0]  m_tdata,
    input  wire logic [0:0]    m_tuser,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    input  wire logic [31:0]   prdata
);

    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Output word dropped while stalled.");

    a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("Output word changed while stalled.");

    a_reset_idle : assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("Output valid during reset.");

    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("Input stalled with no output word waiting.");

    a_readback : assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && !paddr[2]) ##1 (!paddr[2] && !pwrite)
        |-> prdata[15:0] == $past(pwdata[15:0]))
        else $error("Restitution readback mismatch.");

endmodule

bind particle_contact_impulse_core pci_checker u_checker (.*);
`default_nettype wire

### dv/particle_contact_impulse_core_tb.sv
`default_nettype none
module particle_contact_impulse_core_tb;

    typedef struct {
        logic signed [31:0] va [3];
        logic signed [31:0] vb [3];
        logic signed [15:0] n [3];
        logic [31:0] ima;
        logic [31:0] imb;
        logic second;
    } contact_t;

    typedef struct {
        logic [191:0] vel;
        logic resolved;
    } impulse_t;

    class impulse_board;
        impulse_t pending[$];
        int errors;
        logic [15:0] rest;

        function new();
            errors = 0;
            rest = pci_pkg::RESTITUTION_RESET;
        endfunction

        function logic [31:0] clamp(logic signed [63:0] x);
            if (x > 64'sd2147483647)
                return 32'h7fffffff;
            if (x < -64'sd2147483648)
                return 32'h80000000;
            return x[31:0];
        endfunction

        function void note_contact(contact_t c);
            impulse_t r;
            logic signed [63:0] s;
            logic signed [63:0] vbe;
            logic signed [63:0] da;
            logic signed [63:0] db;
            logic [32:0] total;
            logic [63:0] c16;
            logic [63:0] dv;
            logic [63:0] mag;
            logic [63:0] m;
            logic [95:0] ra;
            logic [95:0] rb;
            logic [127:0] pa;
            logic [127:0] pb;
            logic [31:0] imb;
            imb = c.second ? c.imb : 32'd0;
            total = {1'b0, c.ima} + {1'b0, imb};
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                vbe = c.second ? 64'(c.vb[i]) : 64'sd0;
                s += (64'(c.va[i]) - vbe) * 64'(c.n[i]);
            end
            if (s > 0 || total == 0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    r.vel[32*i +: 32] = c.va[i];
                    r.vel[32*(i+3) +: 32] = c.vb[i];
                end
                r.resolved = 1'b0;
            end
            else
            begin
                c16 = (-s) >>> 14;
                dv = (c16 * (64'd32768 + 64'(rest))) >> 15;
                ra = ({64'(c.ima), 32'd0}) / 96'(total);
                rb = ({64'(imb), 32'd0}) / 96'(total);
                for (int i = 0; i < 3; i++)
                begin
                    mag = c.n[i] < 0 ? 64'(-64'(c.n[i])) : 64'(c.n[i]);
                    m = (dv * mag) >> 14;
                    pa = (128'(m) * 128'(ra)) >> 32;
                    pb = (128'(m) * 128'(rb)) >> 32;
                    da = pa[63:0];
                    db = pb[63:0];
                    if (c.n[i] < 0)
                    begin
                        da = -da;
                        db = -db;
                    end
                    r.vel[32*i +: 32] = clamp(64'(c.va[i]) + da);
                    r.vel[32*(i+3) +: 32] = clamp(64'(c.vb[i]) - db);
                end
                r.resolved = 1'b1;
            end
            pending.push_back(r);
        endfunction

        function void check_impulse(logic [191:0] vel, logic resolved);
            impulse_t e;
            string names [6] = '{"new_a_x", "new_a_y", "new_a_z",
                                 "new_b_x", "new_b_y", "new_b_z"};
            if (pending.size() == 0)
            begin
                $error("unexpected word on master side");
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < 6; i++)
                if (vel[32*i +: 32] !== e.vel[32*i +: 32])
                begin
                    $error("%s expected %0d actual %0d", names[i],
                           $signed(e.vel[32*i +: 32]), $signed(vel[32*i +: 32]));
                    errors++;
                end
            if (resolved !== e.resolved)
            begin
                $error("resolved expected %0d actual %0d", e.resolved, resolved);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [303:0] s_tdata;
    logic [0:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [191:0] m_tdata;
    logic [0:0] m_tuser;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    impulse_board board;
    bit calm;

    particle_contact_impulse_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_impulse(m_tdata, m_tuser[0]);
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
    end

    task automatic write_restitution(logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * pci_pkg::REG_RESTITUTION);
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.rest = value;
    endtask

    task automatic send_contact(contact_t c);
        logic [303:0] d;
        for (int i = 0; i < 3; i++)
        begin
            d[32*i +: 32] = c.va[i];
            d[32*(i+3) +: 32] = c.vb[i];
            d[192 + 16*i +: 16] = c.n[i];
        end
        d[240 +: 32] = c.ima;
        d[272 +: 32] = c.imb;
        while (!calm && $urandom_range(99) < 6)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= c.second;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_contact(c);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
        endcase
    endfunction

    function automatic logic [15:0] rand_norm();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return $urandom;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(6))
            0: return 32'd0;
            1: return 32'hffffffff;
            2: return $urandom;
            default: return $urandom_range(4 << 16);
        endcase
    endfunction

    function automatic contact_t rand_contact();
        contact_t c;
        for (int i = 0; i < 3; i++)
        begin
            c.va[i] = rand_vel();
            c.vb[i] = rand_vel();
            c.n[i] = rand_norm();
        end
        c.ima = rand_mass();
        c.imb = rand_mass();
        c.second = ($urandom_range(3) != 0);
        return c;
    endfunction

    initial
    begin
        contact_t c;
        logic [15:0] rests [5] = '{16'd0, 16'd16384, 16'd65535, 16'd32768, 16'd40000};
        board = new();
        calm = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed contacts: head-on, separating, zero speed, immovable, scenery, extremes, then random ones.
        for (int k = 0; k < 20; k++)
        begin
            c = rand_contact();
            for (int i = 0; i < 3; i++)
            begin
                c.va[i] = 0;
                c.vb[i] = 0;
                c.n[i] = 0;
            end
            c.n[0] = 16384;
            c.ima = 32'h10000;
            c.imb = 32'h10000;
            c.second = 1'b1;
            case (k)
                0: c.va[0] = -(1 << 16);
                1: c.va[0] = 1 << 16;
                2: ;
                3: begin c.va[0] = -(1 << 16); c.ima = 0; c.imb = 0; end
                4: begin c.va[0] = -(1 << 16); c.second = 1'b0; end
                5: begin c.va[0] = 32'h80000000; c.vb[0] = 32'h7fffffff;
                         c.n[0] = 16'h7fff; c.ima = 32'hffffffff; c.imb = 32'hffffffff; end
                6: begin c.va[0] = 32'h7fffffff; c.vb[0] = 32'h80000000;
                         c.n[0] = 16'h8000; end
                7: begin c.va[1] = 32'h80000000; c.n[1] = 16'h8000;
                         c.n[2] = 16'h8000; c.vb[2] = 32'h7fffffff; end
                8: begin c.va[0] = -(5 << 16); c.imb = 0; end
                9: begin c.va[0] = -(5 << 16); c.ima = 0; end
                10: begin c.va[0] = 32'h80000000; c.second = 1'b0; c.ima = 32'hffffffff;
                          c.vb[0] = 32'h7fffffff; c.vb[1] = 32'h80000000; end
                default: c = rand_contact();
            endcase
            send_contact(c);
        end
        end_burst();
        drain();

        for (int p = 0; p < 5; p++)
        begin
            write_restitution(rests[p]);
            calm = (p == 2);
            for (int k = 0; k < 150; k++)
            begin
                send_contact(rand_contact());
                if (p == 1 && k == 75)
                begin
                    end_burst();
                    while (board.pending.size() != 0)
                        @(posedge clk);
                end
            end
            end_burst();
            calm = 1'b0;
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
rtl/core/pci_pkg.sv
rtl/core/pci_div.sv
rtl/core/pci_front.sv
rtl/core/pci_apply.sv
rtl/core/pci_skid.sv
rtl/core/particle_contact_impulse_core.sv
rtl/core/pci_checker.sv
dv/particle_contact_impulse_core_tb.sv
